// ----- design/rps_pkg.sv -----
// Shared types, constants and state codes of the rarest-piece selector.
package rps_pkg;

    localparam int MAX_PIECES = 1024;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 16;
    localparam int TIE_W      = 11;
    localparam int RAND_W     = 31;
    localparam int PROD_W     = RAND_W + TIE_W;

    localparam logic [RAND_W-1:0] HALF_SCALE = 31'h4000_0000;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_CHOOSE = 1'b1
    } req_t;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  piece_index;
        logic              peer_has_piece;
        logic              own_has_piece;
        logic              piece_busy;
        logic [CNT_W-1:0]  holder_count;
        logic [RAND_W-1:0] random_word;
    } rps_in_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] chosen_index;
        logic [TIE_W-1:0] tie_count;
    } rps_out_t;

    typedef struct packed {
        logic             peer;
        logic             own;
        logic             busy;
        logic [CNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_MUL,
        ST_ROUND,
        ST_SCAN2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic start1;
        logic scan_en;
        logic pass2;
        logic mul_en;
        logic round_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic multi_tie;
        logic out_free;
    } status_t;

endpackage

// ----- design/rps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/rps_ctrl.sv -----
// Controller state machine: sequences writes, both scans, the pick and the result.
module rps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rps_pkg::rps_in_t in_data,
    output logic             in_stall,
    input  rps_pkg::status_t status,
    output rps_pkg::cmd_t    cmd
);
    import rps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_data.req_type == REQ_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.start1 = 1'b1;
                        state_next = ST_SCAN1;
                    end
                end
            end
            ST_SCAN1:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_done)
                begin
                    state_next = status.multi_tie ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                state_next   = ST_SCAN2;
            end
            ST_SCAN2:
            begin
                cmd.scan_en = 1'b1;
                cmd.pass2   = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded while output word still held");

    a_scan2_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN2) |-> ($past(state_reg) == ST_ROUND
                                     || $past(state_reg) == ST_SCAN2))
        else $error("second scan entered without rounding step");

endmodule

// ----- design/rps_datapath.sv -----
// Datapath: piece table, scan counter, minimum/tie tracking, tie pick and result register.
module rps_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rps_pkg::cmd_t     cmd,
    output rps_pkg::status_t  status,
    input  rps_pkg::rps_in_t  in_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [rps_pkg::TIE_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rps_pkg::rps_out_t out_data
);
    import rps_pkg::*;

    logic [TIE_W-1:0]  num_pieces_reg;
    logic [TIE_W-1:0]  limit_reg,  limit_next;
    logic [TIE_W-1:0]  addr_reg,   addr_next;
    logic              pend_reg,   pend_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              any_reg,    any_next;
    logic [TIE_W-1:0]  ties_reg,   ties_next;
    logic [TIE_W-1:0]  k_reg,      k_next;
    logic [IDX_W-1:0]  best_reg,   best_next;
    logic [CNT_W-1:0]  min_reg,    min_next;
    logic [RAND_W-1:0] rand_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              out_valid_reg;
    rps_out_t          out_data_reg;

    entry_t            wr_entry;
    entry_t            rd_entry;
    logic [ENTRY_W-1:0] rd_word;
    logic              issue;
    logic              startable;
    logic [TIE_W-1:0]  ties_m1;
    logic [TIE_W-1:0]  q;
    logic [RAND_W-1:0] rem;
    logic              round_up;

    assign wr_entry.peer  = in_data.peer_has_piece;
    assign wr_entry.own   = in_data.own_has_piece;
    assign wr_entry.busy  = in_data.piece_busy;
    assign wr_entry.count = in_data.holder_count;

    rps_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_PIECES)
    ) u_table (
        .clk  (clk),
        .we   (cmd.wr_en),
        .waddr(in_data.piece_index),
        .wdata(wr_entry),
        .raddr(addr_reg[IDX_W-1:0]),
        .rdata(rd_word)
    );

    assign rd_entry  = entry_t'(rd_word);
    assign startable = rd_entry.peer && !rd_entry.own && !rd_entry.busy;
    assign issue     = cmd.scan_en && (addr_reg < limit_reg);

    assign ties_m1  = ties_reg - TIE_W'(1);
    assign q        = prod_reg[PROD_W-1:RAND_W];
    assign rem      = prod_reg[RAND_W-1:0];
    assign round_up = (rem > HALF_SCALE) || ((rem == HALF_SCALE) && q[0]);

    always_comb
    begin
        limit_next  = limit_reg;
        addr_next   = addr_reg;
        pend_next   = issue;
        rd_idx_next = rd_idx_reg;
        any_next    = any_reg;
        ties_next   = ties_reg;
        k_next      = k_reg;
        best_next   = best_reg;
        min_next    = min_reg;

        if (issue)
        begin
            addr_next   = addr_reg + TIE_W'(1);
            rd_idx_next = addr_reg[IDX_W-1:0];
        end

        // entry read last cycle is evaluated now
        if (pend_reg && startable)
        begin
            if (!cmd.pass2)
            begin
                if (!any_reg || rd_entry.count < min_reg)
                begin
                    any_next  = 1'b1;
                    min_next  = rd_entry.count;
                    best_next = rd_idx_reg;
                    ties_next = TIE_W'(1);
                end
                else if (rd_entry.count == min_reg)
                begin
                    ties_next = ties_reg + TIE_W'(1);
                end
            end
            else if (rd_entry.count == min_reg && k_reg != '0)
            begin
                k_next    = k_reg - TIE_W'(1);
                best_next = rd_idx_reg;
            end
        end

        if (cmd.start1)
        begin
            limit_next = (num_pieces_reg > TIE_W'(MAX_PIECES)) ?
                         TIE_W'(MAX_PIECES) : num_pieces_reg;
            addr_next  = '0;
            pend_next  = 1'b0;
            any_next   = 1'b0;
            ties_next  = '0;
            k_next     = '0;
            best_next  = '0;
        end

        // second scan starts at the first tie; k = 1 + rounded pick
        if (cmd.round_en)
        begin
            k_next    = q + TIE_W'(round_up) + TIE_W'(1);
            addr_next = {1'b0, best_reg};
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_pieces_reg <= '0;
            limit_reg      <= '0;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            any_reg        <= 1'b0;
            ties_reg       <= '0;
            k_reg          <= '0;
            best_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                num_pieces_reg <= cfg_data;
            end
            limit_reg <= limit_next;
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
            any_reg   <= any_next;
            ties_reg  <= ties_next;
            k_reg     <= k_next;
            best_reg  <= best_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        min_reg    <= min_next;
        if (cmd.start1)
        begin
            rand_reg <= in_data.random_word;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(rand_reg) * PROD_W'(ties_m1);
        end
        if (cmd.load_out)
        begin
            out_data_reg.found        <= any_reg;
            out_data_reg.chosen_index <= any_reg ? best_reg : '0;
            out_data_reg.tie_count    <= any_reg ? ties_reg : '0;
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.scan_done = !(addr_reg < limit_reg) && !pend_reg;
    assign status.multi_tie = ties_reg > TIE_W'(1);
    assign status.out_free  = !out_valid_reg || !out_stall;

    a_any_ties: assert property (@(posedge clk) disable iff (!rst_n)
        any_reg == (ties_reg != '0))
        else $error("tie count disagrees with found flag");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= ties_reg)
        else $error("tie pick beyond tie count");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        addr_reg <= limit_reg)
        else $error("scan address past limit");

endmodule

// ----- design/rarest_piece_selector.sv -----
// Top level of the rarest-first piece selector: controller plus datapath.
//
//  channel | handshake           | word
//  in      | in_valid / in_stall | rps_in_t: write entry or choose request
//  out     | out_valid/out_stall | rps_out_t: found, chosen_index, tie_count
//  cfg     | cfg_valid/cfg_ready | num_pieces (11 bits)
//
// A write word is accepted in idle without a stall. A choose word keeps in_stall
// high until its result is loaded: over a scan of min(num_pieces, 1024) entries and,
// when several pieces tie, a second scan from the first least-count piece; both scans
// read the piece table one entry per cycle through its single read port.
// Reset clears control state only; table entries are undefined until written.
// A finished result waits in the output register under out_stall; new words
// are taken meanwhile, and a later choose result holds until that slot frees.
module rarest_piece_selector (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  rps_pkg::rps_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output rps_pkg::rps_out_t         out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rps_pkg::TIE_W-1:0] cfg_data
);
    import rps_pkg::*;

    cmd_t    cmd;
    status_t status;

    rps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_data (in_data),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    rps_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (in_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule
